// ===== src/image_range_alias_table_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the image range alias table
// Property wrappers clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef IMAGE_RANGE_ALIAS_TABLE_CORE_MACROS_SVH
`define IMAGE_RANGE_ALIAS_TABLE_CORE_MACROS_SVH

// property must hold at every edge out of reset
`define IRAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define IRAT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/irat_pkg.sv =====
// ---------------------------------------------------------------------------
// irat_pkg
// Shared constants, codes and helpers of the image range alias table.
// ---------------------------------------------------------------------------
package irat_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int ID_BITS_DEF = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;

  localparam int ADDR_W = 64;
  localparam int VIEW_W = 8;
  localparam int ORD_W  = 32;

  // entry layout, low fields first; the image id sits above START
  localparam int ORD_LSB   = 0;
  localparam int VIEW_LSB  = ORD_LSB + ORD_W;
  localparam int TICK_LSB  = VIEW_LSB + VIEW_W;
  localparam int GEN_LSB   = TICK_LSB + ADDR_W;
  localparam int LEN_LSB   = GEN_LSB + ADDR_W;
  localparam int START_LSB = LEN_LSB + ADDR_W;
  localparam int IMG_LSB   = START_LSB + ADDR_W;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_UNREGISTER = 3'd1,
    OP_NOTIFY     = 3'd2,
    OP_FIND       = 3'd3,
    OP_READ_INFO  = 3'd4,
    OP_READ_GEN   = 3'd5,
    OP_CANONICAL  = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_ZERO     = 3'd1,
    STS_DUP      = 3'd2,
    STS_NOT_REG  = 3'd3,
    STS_FULL     = 3'd4
  } status_e;

  // half-open ranges [as, ae) and [bs, be), ends already wrapped
  function automatic logic ranges_overlap(logic [ADDR_W-1:0] as, logic [ADDR_W-1:0] ae,
                                          logic [ADDR_W-1:0] bs, logic [ADDR_W-1:0] be);
    ranges_overlap = (as < be) && (bs < ae);
  endfunction

endpackage

// ===== src/irat_slot_mem.sv =====
// ---------------------------------------------------------------------------
// irat_slot_mem
// Slot storage: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module irat_slot_mem
  import irat_pkg::*;
#(
  parameter int DEPTH = ENTRIES_DEF,
  parameter int WIDTH = ID_BITS_DEF + IMG_LSB,
  parameter int AW    = $clog2(ENTRIES_DEF)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/image_range_alias_table_core.sv =====
// ---------------------------------------------------------------------------
// image_range_alias_table_core
// Table of image address ranges with overlap queries and ordered listings.
// ---------------------------------------------------------------------------
// One request is handled at a time. Every request first sweeps all ENTRIES
// slots of the slot memory to find its image id (S_LOOK, one read per
// cycle from the registered read port), then decides and writes back in
// S_ACT. Notify of a registered id, find with a nonzero size and canonical
// check of a registered id sweep the memory once more (S_SCAN) for slots
// that overlap; notify and find mark them, canonical check compares their
// ticks. Each listed id then costs one further sweep (S_SORT) that picks the
// smallest remaining key, and S_PUT hands it to the output register.
// Results leave through an output register, so a new request is taken while
// the last result of the previous one still waits on out_stall_i.
// ---------------------------------------------------------------------------
module image_range_alias_table_core
  import irat_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] image_id_i,
  input  logic [63:0] range_start_i,
  input  logic [63:0] range_size_i,
  input  logic [7:0]  view_kind_i,
  input  logic [63:0] write_tick_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        answer_flag_o,
  output logic        item_present_o,
  output logic [15:0] item_id_o,
  output logic        last_item_o,
  output logic [63:0] info_start_o,
  output logic [63:0] info_size_o,
  output logic [63:0] info_generation_o,
  output logic [63:0] info_tick_o,
  output logic [7:0]  info_view_o
);

`include "image_range_alias_table_core_macros.svh"

  localparam int IdxW = $clog2(ENTRIES);
  localparam int EntW = ID_BITS + IMG_LSB;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;  // sweep for the request's id
  localparam logic [2:0] S_ACT  = 3'd2;  // decide, write back
  localparam logic [2:0] S_SCAN = 3'd3;  // sweep for overlaps
  localparam logic [2:0] S_SORT = 3'd4;  // sweep for next smallest key
  localparam logic [2:0] S_PUT  = 3'd5;  // hand result to output register

  logic [2:0] state_q, state_d;

  // request
  op_e               op_q, op_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [63:0]       start_q, start_d, size_q, size_d, tick_q, tick_d;
  logic [7:0]        view_q, view_d;
  logic [31:0]       id_ext;

  // table control
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ORD_W-1:0]   order_q, order_d;
  logic [ENTRIES-1:0] hits_q, hits_d, hits_nx;

  // sweep control
  logic [IdxW-1:0] scan_cnt_q, scan_cnt_d, rd_idx_q, rd_idx_d;
  logic            iss_done_q, iss_done_d, rd_act_q, rd_act_d, last_proc;

  // lookup result
  logic            found_q, found_d;
  logic [IdxW-1:0] s_idx_q, s_idx_d;
  logic [EntW-1:0] s_ent_q, s_ent_d;

  // query window and list mode
  logic [63:0] q_start_q, q_start_d, q_end_q, q_end_d;
  logic        by_id_q, by_id_d, excl_q, excl_d, canon_q, canon_d;

  // selection sweep
  logic               best_vld_q, best_vld_d;
  logic [IdxW-1:0]    best_idx_q, best_idx_d;
  logic [ID_BITS-1:0] best_img_q, best_img_d;
  logic [63:0]        best_start_q, best_start_d;
  logic [ORD_W-1:0]   best_ord_q, best_ord_d;
  logic [CNT_W-1:0]   emit_cnt_q, emit_cnt_d;

  // pending result
  logic [2:0]  res_status_q, res_status_d;
  logic        res_flag_q, res_flag_d, res_present_q, res_present_d;
  logic        res_last_q, res_last_d, res_all_q, res_all_d, res_gen_q, res_gen_d;
  logic [15:0] res_id_q, res_id_d;
  logic [31:0] best_id_ext;

  // output register
  logic        out_valid_q, out_valid_d, out_free;
  logic [2:0]  o_status_q, o_status_d;
  logic        o_flag_q, o_flag_d, o_present_q, o_present_d, o_last_q, o_last_d;
  logic [15:0] o_id_q, o_id_d;
  logic [63:0] o_start_q, o_start_d, o_size_q, o_size_d;
  logic [63:0] o_gen_q, o_gen_d, o_tick_q, o_tick_d;
  logic [7:0]  o_view_q, o_view_d;

  // memory ports
  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [EntW-1:0] mem_wd, mem_rd;

  // fields of the word just read
  logic [ID_BITS-1:0] r_image;
  logic [63:0]        r_start, r_len, r_tick, r_end;
  logic [ORD_W-1:0]   r_order;
  logic               r_ovl, r_less;

  // fields of the looked-up slot
  logic [ID_BITS-1:0] s_image;
  logic [63:0]        s_start, s_len, s_gen, s_tick;
  logic [7:0]         s_view;
  logic [ORD_W-1:0]   s_order;

  logic            free_any, reg_ok;
  logic [IdxW-1:0] free_idx;

  irat_slot_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (EntW),
    .AW    (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (scan_cnt_q),
    .rdata_o (mem_rd)
  );

  assign id_ext      = {16'b0, image_id_i};
  assign best_id_ext = 32'(best_img_d);

  assign r_image = mem_rd[IMG_LSB +: ID_BITS];
  assign r_start = mem_rd[START_LSB +: 64];
  assign r_len   = mem_rd[LEN_LSB +: 64];
  assign r_tick  = mem_rd[TICK_LSB +: 64];
  assign r_order = mem_rd[ORD_LSB +: ORD_W];
  assign r_end   = r_start + r_len;

  assign s_image = s_ent_q[IMG_LSB +: ID_BITS];
  assign s_start = s_ent_q[START_LSB +: 64];
  assign s_len   = s_ent_q[LEN_LSB +: 64];
  assign s_gen   = s_ent_q[GEN_LSB +: 64];
  assign s_tick  = s_ent_q[TICK_LSB +: 64];
  assign s_view  = s_ent_q[VIEW_LSB +: VIEW_W];
  assign s_order = s_ent_q[ORD_LSB +: ORD_W];

  assign r_ovl = valid_q[rd_idx_q] && !(excl_q && (rd_idx_q == s_idx_q)) &&
                 ranges_overlap(r_start, r_end, q_start_q, q_end_q);
  assign r_less = by_id_q ? (r_image < best_img_q)
                          : ((r_start < best_start_q) ||
                             ((r_start == best_start_q) && (r_order < best_ord_q)));

  assign last_proc = rd_act_q && (rd_idx_q == LastIdx);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign reg_ok = (state_q == S_ACT) && (op_q == OP_REGISTER) && (size_q != '0) &&
                  !found_q && free_any;

  always_comb begin
    state_d = state_q;
    op_d = op_q; id_d = id_q; start_d = start_q; size_d = size_q;
    tick_d = tick_q; view_d = view_q;
    valid_d = valid_q; order_d = order_q; hits_d = hits_q; hits_nx = hits_q;
    found_d = found_q; s_idx_d = s_idx_q; s_ent_d = s_ent_q;
    q_start_d = q_start_q; q_end_d = q_end_q;
    by_id_d = by_id_q; excl_d = excl_q; canon_d = canon_q;
    best_vld_d = best_vld_q; best_idx_d = best_idx_q; best_img_d = best_img_q;
    best_start_d = best_start_q; best_ord_d = best_ord_q; emit_cnt_d = emit_cnt_q;
    res_status_d = res_status_q; res_flag_d = res_flag_q; res_present_d = res_present_q;
    res_last_d = res_last_q; res_all_d = res_all_q; res_gen_d = res_gen_q;
    res_id_d = res_id_q;
    o_status_d = o_status_q; o_flag_d = o_flag_q; o_present_d = o_present_q;
    o_last_d = o_last_q; o_id_d = o_id_q; o_start_d = o_start_q; o_size_d = o_size_q;
    o_gen_d = o_gen_q; o_tick_d = o_tick_q; o_view_d = o_view_q;
    mem_we = 1'b0;
    mem_wa = s_idx_q;
    mem_wd = s_ent_q;

    out_valid_d = out_valid_q && out_stall_i;

    // sweep issue: one read address per cycle
    scan_cnt_d = scan_cnt_q;
    iss_done_d = iss_done_q;
    rd_idx_d   = scan_cnt_q;
    rd_act_d   = 1'b0;
    if (((state_q == S_LOOK) || (state_q == S_SCAN) || (state_q == S_SORT)) &&
        !iss_done_q) begin
      rd_act_d   = 1'b1;
      scan_cnt_d = scan_cnt_q + 1'b1;
      iss_done_d = (scan_cnt_q == LastIdx);
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = op_e'(operation_i);
          id_d = id_ext[ID_BITS-1:0];
          start_d = range_start_i;
          size_d = range_size_i;
          view_d = view_kind_i;
          tick_d = write_tick_i;
          found_d = 1'b0;
          hits_d = '0;
          scan_cnt_d = '0;
          iss_done_d = 1'b0;
          state_d = S_LOOK;
        end
      end

      S_LOOK: begin
        if (rd_act_q && valid_q[rd_idx_q] && (r_image == id_q) && !found_q) begin
          found_d = 1'b1;
          s_idx_d = rd_idx_q;
          s_ent_d = mem_rd;
        end
        if (last_proc) begin
          state_d = S_ACT;
        end
      end

      S_ACT: begin
        res_status_d = STS_OK;
        res_flag_d = 1'b0;
        res_present_d = 1'b0;
        res_id_d = '0;
        res_last_d = 1'b1;
        res_all_d = 1'b0;
        res_gen_d = 1'b0;
        emit_cnt_d = '0;
        q_start_d = start_q;
        q_end_d = start_q + size_q;
        excl_d = 1'b1;
        by_id_d = 1'b0;
        canon_d = 1'b0;
        state_d = S_PUT;
        unique case (op_q)
          OP_REGISTER: begin
            if (size_q == '0) begin
              res_status_d = STS_ZERO;
            end else if (found_q) begin
              res_status_d = STS_DUP;
            end else if (!free_any) begin
              res_status_d = STS_FULL;
            end else begin
              mem_we = 1'b1;
              mem_wa = free_idx;
              mem_wd = {id_q, start_q, size_q, 64'd0, 64'd0, view_q, order_q};
              valid_d[free_idx] = 1'b1;
              order_d = order_q + 1'b1;
            end
          end
          OP_UNREGISTER: begin
            if (found_q) begin
              valid_d[s_idx_q] = 1'b0;
              res_flag_d = 1'b1;
            end
          end
          OP_NOTIFY: begin
            if (!found_q) begin
              res_status_d = STS_NOT_REG;
            end else begin
              mem_we = 1'b1;
              mem_wd = {s_image, s_start, s_len, s_gen + 64'd1, tick_q, s_view, s_order};
              q_start_d = s_start;
              q_end_d = s_start + s_len;
              scan_cnt_d = '0;
              iss_done_d = 1'b0;
              state_d = S_SCAN;
            end
          end
          OP_FIND: begin
            if (size_q != '0) begin
              excl_d = 1'b0;
              by_id_d = 1'b1;
              scan_cnt_d = '0;
              iss_done_d = 1'b0;
              state_d = S_SCAN;
            end
          end
          OP_READ_INFO: begin
            res_flag_d = found_q;
            res_all_d = found_q;
          end
          OP_READ_GEN: begin
            res_gen_d = found_q;
          end
          OP_CANONICAL: begin
            if (found_q) begin
              canon_d = 1'b1;
              res_flag_d = 1'b1;
              scan_cnt_d = '0;
              iss_done_d = 1'b0;
              state_d = S_SCAN;
            end
          end
          OP_CLEAR: begin
            valid_d = '0;
            order_d = '0;
          end
        endcase
      end

      S_SCAN: begin
        if (rd_act_q && r_ovl) begin
          if (canon_q) begin
            if (r_tick > s_tick) begin
              res_flag_d = 1'b0;
            end
          end else begin
            hits_d[rd_idx_q] = 1'b1;
          end
        end
        if (last_proc) begin
          state_d = S_PUT;
          if (!canon_q && (hits_d != '0)) begin
            best_vld_d = 1'b0;
            scan_cnt_d = '0;
            iss_done_d = 1'b0;
            state_d = S_SORT;
          end
        end
      end

      S_SORT: begin
        if (rd_act_q && hits_q[rd_idx_q] && (!best_vld_q || r_less)) begin
          best_vld_d = 1'b1;
          best_idx_d = rd_idx_q;
          best_img_d = r_image;
          best_start_d = r_start;
          best_ord_d = r_order;
        end
        if (last_proc) begin
          hits_nx[best_idx_d] = 1'b0;
          emit_cnt_d = emit_cnt_q + 1'b1;
          res_present_d = 1'b1;
          res_id_d = best_id_ext[15:0];
          res_last_d = (hits_nx == '0) || (emit_cnt_d == CNT_W'(MAX_RESULTS));
          hits_d = res_last_d ? '0 : hits_nx;
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_status_d = res_status_q;
          o_flag_d = res_flag_q;
          o_present_d = res_present_q;
          o_id_d = res_id_q;
          o_last_d = res_last_q;
          o_start_d = res_all_q ? s_start : '0;
          o_size_d = res_all_q ? s_len : '0;
          o_gen_d = (res_all_q || res_gen_q) ? s_gen : '0;
          o_tick_d = res_all_q ? s_tick : '0;
          o_view_d = res_all_q ? s_view : '0;
          if (res_last_q) begin
            state_d = S_IDLE;
          end else begin
            best_vld_d = 1'b0;
            scan_cnt_d = '0;
            iss_done_d = 1'b0;
            state_d = S_SORT;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      order_q <= '0;
      hits_q <= '0;
      scan_cnt_q <= '0;
      iss_done_q <= 1'b1;
      rd_act_q <= 1'b0;
      out_valid_q <= 1'b0;
      emit_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      order_q <= order_d;
      hits_q <= hits_d;
      scan_cnt_q <= scan_cnt_d;
      iss_done_q <= iss_done_d;
      rd_act_q <= rd_act_d;
      out_valid_q <= out_valid_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    op_q <= op_d; id_q <= id_d; start_q <= start_d; size_q <= size_d;
    tick_q <= tick_d; view_q <= view_d;
    rd_idx_q <= rd_idx_d;
    found_q <= found_d; s_idx_q <= s_idx_d; s_ent_q <= s_ent_d;
    q_start_q <= q_start_d; q_end_q <= q_end_d;
    by_id_q <= by_id_d; excl_q <= excl_d; canon_q <= canon_d;
    best_vld_q <= best_vld_d; best_idx_q <= best_idx_d; best_img_q <= best_img_d;
    best_start_q <= best_start_d; best_ord_q <= best_ord_d;
    res_status_q <= res_status_d; res_flag_q <= res_flag_d;
    res_present_q <= res_present_d; res_last_q <= res_last_d;
    res_all_q <= res_all_d; res_gen_q <= res_gen_d; res_id_q <= res_id_d;
    o_status_q <= o_status_d; o_flag_q <= o_flag_d; o_present_q <= o_present_d;
    o_last_q <= o_last_d; o_id_q <= o_id_d; o_start_q <= o_start_d;
    o_size_q <= o_size_d; o_gen_q <= o_gen_d; o_tick_q <= o_tick_d;
    o_view_q <= o_view_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = o_status_q;
  assign answer_flag_o     = o_flag_q;
  assign item_present_o    = o_present_q;
  assign item_id_o         = o_id_q;
  assign last_item_o       = o_last_q;
  assign info_start_o      = o_start_q;
  assign info_size_o       = o_size_q;
  assign info_generation_o = o_gen_q;
  assign info_tick_o       = o_tick_q;
  assign info_view_o       = o_view_q;

  // no memory sweep in flight while waiting for a request
  `IRAT_ASSERT(a_idle_no_read, (state_q == S_IDLE) |-> !rd_act_q, "read active in idle")
  // overlap marks only ever point at live slots
  `IRAT_NEVER(a_hits_live, (hits_q & ~valid_q) != '0, "overlap mark on free slot")
  // a listing never runs past its cap
  `IRAT_NEVER(a_cnt_cap, emit_cnt_q > CNT_W'(MAX_RESULTS), "listing past cap")
  // a successful registration takes exactly one slot
  `IRAT_ASSERT(a_reg_grows, reg_ok |=> ($countones(valid_q) == $past($countones(valid_q)) + 1), "registration did not take one slot")

endmodule
